[hw/rtl/frequency_ordered_list_defines.svh]
// Assertion macros for the checker file of the ordered list block.
`ifndef FREQUENCY_ORDERED_LIST_DEFINES_SVH
`define FREQUENCY_ORDERED_LIST_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FOL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FOL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

[hw/rtl/fol_pkg.sv]
package fol_pkg;

    // Default sizing of the table.
    localparam int FOL_DEPTH      = 16;
    localparam int FOL_COUNT_BITS = 16;

    // Fixed field widths.
    localparam int KEY_W       = 32;
    localparam int SEQ_W       = 16;
    localparam int POS_W       = 4;
    localparam int CNT_OUT_W   = 16;
    localparam int MAX_RESULTS = 16;

    localparam logic [SEQ_W-1:0] SEQ_MAX = {SEQ_W{1'b1}};

    // Input action codes.
    localparam logic [1:0] ACT_APPEND = 2'd0;
    localparam logic [1:0] ACT_ACCESS = 2'd1;
    localparam logic [1:0] ACT_DUMP   = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    // Which result the datapath loads into the output register.
    typedef enum logic [2:0] {
        RES_APPEND = 3'd0,
        RES_FULL   = 3'd1,
        RES_MISS   = 3'd2,
        RES_ACCESS = 3'd3,
        RES_EMPTY  = 3'd4,
        RES_DUMP   = 3'd5
    } res_kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      start;
        logic      rd_idx;
        logic      rd_prev;
        logic      idx_inc;
        logic      hit_take;
        logic      move_write;
        logic      place_write;
        logic      append_write;
        logic      out_load;
        res_kind_t res;
    } fol_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic hit;
        logic scan_end;
        logic stop;
        logic idx_zero;
        logic idx_one;
        logic dump_last;
        logic out_free;
    } fol_sts_t;

endpackage

[hw/rtl/fol_in_if.sv]
interface fol_in_if;
    import fol_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [1:0]              action;
    logic signed [KEY_W-1:0] key;

    modport source (output valid, output action, output key, input ready);
    modport sink (input valid, input action, input key, output ready);
endinterface

[hw/rtl/fol_out_if.sv]
interface fol_out_if;
    import fol_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic signed [KEY_W-1:0] entry_value;
    logic [CNT_OUT_W-1:0]    access_count;
    logic [POS_W-1:0]        position;
    logic                    last;

    modport source (
        output valid, output status, output entry_value, output access_count,
        output position, output last, input ready
    );
    modport sink (
        input valid, input status, input entry_value, input access_count,
        input position, input last, output ready
    );
endinterface

[hw/rtl/fol_ram.sv]
module fol_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hw/rtl/fol_ctrl.sv]
module fol_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [1:0]       in_action,
    output logic             in_ready,
    input  fol_pkg::fol_sts_t sts,
    output fol_pkg::fol_cmd_t cmd
);
    import fol_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_APPEND    = 11'b000_0000_0010,
        S_SCAN_RD   = 11'b000_0000_0100,
        S_SCAN_CMP  = 11'b000_0000_1000,
        S_MOVE_RD   = 11'b000_0001_0000,
        S_MOVE_CMP  = 11'b000_0010_0000,
        S_PLACE     = 11'b000_0100_0000,
        S_MISS      = 11'b000_1000_0000,
        S_EMPTY     = 11'b001_0000_0000,
        S_DUMP_RD   = 11'b010_0000_0000,
        S_DUMP_EMIT = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res    = RES_APPEND;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (in_action)
                        ACT_APPEND:
                        begin
                            cmd.start  = 1'b1;
                            state_next = S_APPEND;
                        end
                        ACT_ACCESS:
                        begin
                            cmd.start  = 1'b1;
                            state_next = sts.empty ? S_MISS : S_SCAN_RD;
                        end
                        ACT_DUMP:
                        begin
                            cmd.start  = 1'b1;
                            state_next = sts.empty ? S_EMPTY : S_DUMP_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_APPEND:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load     = 1'b1;
                    cmd.res          = sts.full ? RES_FULL : RES_APPEND;
                    cmd.append_write = !sts.full;
                    state_next       = S_IDLE;
                end
            end
            S_SCAN_RD:
            begin
                cmd.rd_idx = 1'b1;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (sts.hit)
                begin
                    cmd.hit_take = 1'b1;
                    state_next   = sts.idx_zero ? S_PLACE : S_MOVE_RD;
                end
                else if (sts.scan_end)
                begin
                    state_next = S_MISS;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end
            S_MOVE_RD:
            begin
                cmd.rd_prev = 1'b1;
                state_next  = S_MOVE_CMP;
            end
            S_MOVE_CMP:
            begin
                if (sts.stop)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    cmd.move_write = 1'b1;
                    state_next     = sts.idx_one ? S_PLACE : S_MOVE_RD;
                end
            end
            S_PLACE:
            begin
                if (sts.out_free)
                begin
                    cmd.place_write = 1'b1;
                    cmd.out_load    = 1'b1;
                    cmd.res         = RES_ACCESS;
                    state_next      = S_IDLE;
                end
            end
            S_MISS:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.res      = RES_MISS;
                    state_next   = S_IDLE;
                end
            end
            S_EMPTY:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.res      = RES_EMPTY;
                    state_next   = S_IDLE;
                end
            end
            S_DUMP_RD:
            begin
                cmd.rd_idx = 1'b1;
                state_next = S_DUMP_EMIT;
            end
            S_DUMP_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.res      = RES_DUMP;
                    if (sts.dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_DUMP_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/fol_datapath.sv]
module fol_datapath #(
    parameter int DEPTH      = fol_pkg::FOL_DEPTH,
    parameter int COUNT_BITS = fol_pkg::FOL_COUNT_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic signed [fol_pkg::KEY_W-1:0] in_key,
    input  fol_pkg::fol_cmd_t               cmd,
    output fol_pkg::fol_sts_t               sts,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      out_status,
    output logic signed [fol_pkg::KEY_W-1:0] out_entry_value,
    output logic [fol_pkg::CNT_OUT_W-1:0]   out_access_count,
    output logic [fol_pkg::POS_W-1:0]       out_position,
    output logic                            out_last
);
    import fol_pkg::*;

    localparam int IDX_W   = $clog2(DEPTH);
    localparam int USED_W  = $clog2(DEPTH + 1);
    localparam int ENTRY_W = KEY_W + SEQ_W + COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    logic [USED_W-1:0]     used_reg;
    logic [SEQ_W-1:0]      next_seq_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [COUNT_BITS-1:0] cnt_new_reg;
    logic [SEQ_W-1:0]      seq_new_reg;

    logic [ENTRY_W-1:0]    ram_rd_data;
    logic [ENTRY_W-1:0]    ram_wr_data;
    logic [IDX_W-1:0]      ram_wr_addr;
    logic [IDX_W-1:0]      ram_rd_addr;
    logic                  ram_wr_en;
    logic [KEY_W-1:0]      rd_key;
    logic [SEQ_W-1:0]      rd_seq;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic [IDX_W-1:0]      idx_prev;
    logic [USED_W-1:0]     used_m1;

    logic                  out_valid_reg;
    logic [1:0]            status_reg;
    logic [KEY_W-1:0]      value_reg;
    logic [CNT_OUT_W-1:0]  count_reg;
    logic [POS_W-1:0]      pos_reg;
    logic                  last_reg;

    // Entry layout: key on top, first-access sequence, then the count.
    assign rd_key   = ram_rd_data[ENTRY_W-1 -: KEY_W];
    assign rd_seq   = ram_rd_data[COUNT_BITS +: SEQ_W];
    assign rd_cnt   = ram_rd_data[COUNT_BITS-1:0];
    assign idx_prev = idx_reg - 1'b1;
    assign used_m1  = used_reg - 1'b1;

    // Table storage.
    assign ram_rd_addr = cmd.rd_prev ? idx_prev : idx_reg;
    assign ram_wr_en   = cmd.append_write || cmd.move_write || cmd.place_write;
    assign ram_wr_addr = cmd.append_write ? IDX_W'(used_reg) : idx_reg;

    always_comb
    begin
        if (cmd.append_write)
        begin
            ram_wr_data = {key_reg, {SEQ_W{1'b0}}, {COUNT_BITS{1'b0}}};
        end
        else if (cmd.place_write)
        begin
            ram_wr_data = {key_reg, seq_new_reg, cnt_new_reg};
        end
        else
        begin
            ram_wr_data = ram_rd_data;
        end
    end

    fol_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.rd_idx || cmd.rd_prev),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Status toward the controller.
    assign sts.full      = (used_reg == USED_W'(DEPTH));
    assign sts.empty     = (used_reg == '0);
    assign sts.hit       = (rd_key == key_reg);
    assign sts.scan_end  = (USED_W'(idx_reg) == used_m1);
    assign sts.stop      = (rd_cnt > cnt_new_reg) ||
                           ((rd_cnt == cnt_new_reg) && (rd_seq < seq_new_reg));
    assign sts.idx_zero  = (idx_reg == '0);
    assign sts.idx_one   = (idx_reg == IDX_W'(1));
    assign sts.dump_last = (USED_W'(idx_reg) == used_m1) ||
                           (32'(idx_reg) == 32'(MAX_RESULTS - 1));
    assign sts.out_free  = !out_valid_reg || out_ready;

    // Table bookkeeping and the scan / move index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= '0;
            next_seq_reg <= SEQ_W'(1);
            idx_reg      <= '0;
        end
        else
        begin
            if (cmd.append_write)
            begin
                used_reg <= used_reg + 1'b1;
            end
            if (cmd.hit_take && (rd_seq == '0) && (next_seq_reg != SEQ_MAX))
            begin
                next_seq_reg <= next_seq_reg + 1'b1;
            end
            if (cmd.start)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            else if (cmd.move_write)
            begin
                idx_reg <= idx_prev;
            end
        end
    end

    // Operand and the updated count and sequence of the hit entry.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg <= in_key;
        end
        if (cmd.hit_take)
        begin
            cnt_new_reg <= (rd_cnt == CMAX) ? rd_cnt : rd_cnt + 1'b1;
            seq_new_reg <= (rd_seq == '0) ? next_seq_reg : rd_seq;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload. Only a dump result can be followed by another.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            last_reg <= (cmd.res == RES_DUMP) ? sts.dump_last : 1'b1;
            case (cmd.res)
                RES_APPEND:
                begin
                    status_reg <= ST_OK;
                    value_reg  <= key_reg;
                    count_reg  <= '0;
                    pos_reg    <= POS_W'(used_reg);
                end
                RES_FULL:
                begin
                    status_reg <= ST_FULL;
                    value_reg  <= key_reg;
                    count_reg  <= '0;
                    pos_reg    <= '0;
                end
                RES_MISS:
                begin
                    status_reg <= ST_NOT_FOUND;
                    value_reg  <= key_reg;
                    count_reg  <= '0;
                    pos_reg    <= '0;
                end
                RES_ACCESS:
                begin
                    status_reg <= ST_OK;
                    value_reg  <= key_reg;
                    count_reg  <= CNT_OUT_W'(cnt_new_reg);
                    pos_reg    <= POS_W'(idx_reg);
                end
                RES_DUMP:
                begin
                    status_reg <= ST_OK;
                    value_reg  <= rd_key;
                    count_reg  <= CNT_OUT_W'(rd_cnt);
                    pos_reg    <= POS_W'(idx_reg);
                end
                default:
                begin
                    status_reg <= ST_EMPTY;
                    value_reg  <= '0;
                    count_reg  <= '0;
                    pos_reg    <= '0;
                end
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_status       = status_reg;
    assign out_entry_value  = value_reg;
    assign out_access_count = count_reg;
    assign out_position     = pos_reg;
    assign out_last         = last_reg;

endmodule

[hw/rtl/frequency_ordered_list.sv]
// Frequency-ordered list: a table of up to DEPTH keys kept in order of access
// count, ties broken by the order of first access.
// Input channel (in_ch): one transaction per command, action plus key.
// Append adds the key at the tail, access counts it and moves it forward, dump
// reads the whole table. Output channel (out_ch): one transaction per result;
// append and access give one, dump gives one per entry (at most 16), and last
// marks the final result of a command.
// A new command is taken only while the controller is idle, so one command
// is worked at a time. Append writes the key and loads its result. Access
// reads and compares one entry after another until the hit, then reads and
// moves back each entry that the hit entry passes, then places it; a miss
// reads and compares every entry. Dump reads and emits one entry after
// another. Each read is its own state ahead of its compare or emit state,
// since the read port of the table memory is registered.
// Reset empties the table and sets the sequence counter to one; no memory
// clearing pass is run, the block is ready as soon as reset is released.
// A finished result sits in an output register; while the receiver stalls,
// the block holds that result and can still accept the next command, but
// stops before loading another result until the register frees up.
module frequency_ordered_list #(
    parameter int DEPTH      = fol_pkg::FOL_DEPTH,
    parameter int COUNT_BITS = fol_pkg::FOL_COUNT_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    fol_in_if.sink     in_ch,
    fol_out_if.source  out_ch
);
    import fol_pkg::*;

    fol_cmd_t cmd;
    fol_sts_t sts;

    // Sequencer.
    fol_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_action (in_ch.action),
        .in_ready  (in_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Table storage, bookkeeping and output register.
    fol_datapath #(
        .DEPTH      (DEPTH),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_key           (in_ch.key),
        .cmd              (cmd),
        .sts              (sts),
        .out_valid        (out_ch.valid),
        .out_ready        (out_ch.ready),
        .out_status       (out_ch.status),
        .out_entry_value  (out_ch.entry_value),
        .out_access_count (out_ch.access_count),
        .out_position     (out_ch.position),
        .out_last         (out_ch.last)
    );

endmodule

[hw/rtl/fol_checker.sv]
`include "frequency_ordered_list_defines.svh"

module fol_checker (
    input logic       clk,
    input logic       rst_n,
    fol_in_if.sink    in_ch,
    fol_out_if.source out_ch
);
    import fol_pkg::*;

    logic known_act;

    // Commands that the block works on; any other code is dropped.
    assign known_act = (in_ch.action == ACT_APPEND) || (in_ch.action == ACT_ACCESS) ||
                       (in_ch.action == ACT_DUMP);

    // A stalled result stays offered.
    `FOL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid)

    // A known command keeps the block busy for at least the next cycle.
    `FOL_ASSERT_NEXT(a_busy_after_cmd, clk, rst_n, in_ch.valid && in_ch.ready && known_act, !in_ch.ready)

    // Every error or empty report is the only result of its command.
    `FOL_ASSERT_IMPL(a_err_single, clk, rst_n, out_ch.valid && (out_ch.status != ST_OK), out_ch.last)

    // Miss and full reports carry no count and no position.
    `FOL_ASSERT_IMPL(a_err_fields, clk, rst_n, out_ch.valid && ((out_ch.status == ST_NOT_FOUND) || (out_ch.status == ST_FULL)), (out_ch.access_count == '0) && (out_ch.position == '0))

    // An empty-table report carries a zero value and a zero count.
    `FOL_ASSERT_IMPL(a_empty_zero, clk, rst_n, out_ch.valid && (out_ch.status == ST_EMPTY), (out_ch.entry_value == '0) && (out_ch.access_count == '0))

endmodule

bind frequency_ordered_list fol_checker u_fol_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
);

[tb/sv/tb_frequency_ordered_list.sv]
module tb_frequency_ordered_list;
    timeunit 1ns;
    timeprecision 1ps;

    import fol_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 12;
    localparam int unsigned CNT_MAX = 32'((64'd1 << FOL_COUNT_BITS) - 1);
    localparam int unsigned SEQ_TOP = 32'(SEQ_MAX);

    // Code that no operation uses; the block must drop it silently.
    localparam logic [1:0] ACT_RESERVED = 2'd3;

    localparam int RANDOM_COMMANDS = 220;
    localparam int DRAIN_MARK      = 150;
    localparam int QUIET_TAIL      = 40;
    localparam int HOLD_MARK       = 60;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 80;
    localparam int HAMMER_COMMANDS = 20;
    localparam longint TIMEOUT_NS  = 64'd50_000_000;

    typedef struct packed {
        logic [1:0]           status;
        logic [KEY_W-1:0]     entry_value;
        logic [CNT_OUT_W-1:0] access_count;
        logic [POS_W-1:0]     position;
        logic                 last;
    } report_t;

    typedef struct packed {
        logic [1:0]       act;
        logic [KEY_W-1:0] key;
        bit               typed;
        report_t          rep;
    } cmd_row_t;

    localparam int DIRECTED_ROWS = 21;

    // Hand-written commands. Rows marked typed carry the one result they must give.
    localparam cmd_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{ACT_DUMP,     32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0000_0000, 16'd0, 4'd0, 1'b1}},
        '{ACT_ACCESS,   32'h0000_0005, 1'b1,
          '{ST_NOT_FOUND, 32'h0000_0005, 16'd0, 4'd0, 1'b1}},
        '{ACT_APPEND,   32'h8000_0000, 1'b1, '{ST_OK, 32'h8000_0000, 16'd0, 4'd0, 1'b1}},
        '{ACT_APPEND,   32'h7FFF_FFFF, 1'b1, '{ST_OK, 32'h7FFF_FFFF, 16'd0, 4'd1, 1'b1}},
        '{ACT_APPEND,   32'h0000_0000, 1'b1, '{ST_OK, 32'h0000_0000, 16'd0, 4'd2, 1'b1}},
        '{ACT_APPEND,   32'hFFFF_FFFF, 1'b1, '{ST_OK, 32'hFFFF_FFFF, 16'd0, 4'd3, 1'b1}},
        '{ACT_APPEND,   32'h5A5A_A5A5, 1'b1, '{ST_OK, 32'h5A5A_A5A5, 16'd0, 4'd4, 1'b1}},
        '{ACT_ACCESS,   32'hFFFF_FFFF, 1'b0, '0},
        '{ACT_ACCESS,   32'h0000_0000, 1'b0, '0},
        '{ACT_ACCESS,   32'h0000_0000, 1'b0, '0},
        '{ACT_ACCESS,   32'h7FFF_FFFF, 1'b0, '0},
        '{ACT_ACCESS,   32'h8000_0000, 1'b0, '0},
        '{ACT_APPEND,   32'h0000_0000, 1'b1, '{ST_OK, 32'h0000_0000, 16'd0, 4'd5, 1'b1}},
        '{ACT_ACCESS,   32'h0000_0000, 1'b0, '0},
        '{ACT_RESERVED, 32'h0000_1234, 1'b0, '0},
        '{ACT_ACCESS,   32'h0000_1234, 1'b1,
          '{ST_NOT_FOUND, 32'h0000_1234, 16'd0, 4'd0, 1'b1}},
        '{ACT_DUMP,     32'hFFFF_FFFF, 1'b0, '0},
        '{ACT_ACCESS,   32'h5A5A_A5A5, 1'b0, '0},
        '{ACT_ACCESS,   32'h8000_0000, 1'b0, '0},
        '{ACT_RESERVED, 32'hFFFF_FFFF, 1'b0, '0},
        '{ACT_DUMP,     32'h0000_0000, 1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n;

    fol_in_if  cmd_if ();
    fol_out_if res_if ();

    frequency_ordered_list dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (cmd_if),
        .out_ch (res_if)
    );

    // Shadow copy of the ordered table.
    logic [KEY_W-1:0] tab_key   [FOL_DEPTH];
    int unsigned      tab_count [FOL_DEPTH];
    int unsigned      tab_seq   [FOL_DEPTH];
    int unsigned      tab_used;
    int unsigned      seq_next;

    report_t reports_due [$];
    int      failures      = 0;
    int      commands_sent = 0;
    bit      quiet         = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Update the shadow table for one command and queue the results it gives.
    function automatic void apply_list_command(input logic [1:0] act,
                                               input logic [KEY_W-1:0] k);
        int unsigned hit;
        int unsigned dst;
        int unsigned cnt;
        int unsigned sq;
        int unsigned i;
        bit          found;
        found = 1'b0;
        hit   = 0;
        case (act)
            ACT_APPEND:
            begin
                if (tab_used >= FOL_DEPTH)
                begin
                    reports_due.push_back('{ST_FULL, k, '0, '0, 1'b1});
                end
                else
                begin
                    tab_key[tab_used]   = k;
                    tab_count[tab_used] = 0;
                    tab_seq[tab_used]   = 0;
                    reports_due.push_back('{ST_OK, k, '0, POS_W'(tab_used), 1'b1});
                    tab_used++;
                end
            end
            ACT_ACCESS:
            begin
                for (i = 0; i < tab_used; i++)
                begin
                    if (!found && tab_key[i] == k)
                    begin
                        found = 1'b1;
                        hit   = i;
                    end
                end
                if (!found)
                begin
                    reports_due.push_back('{ST_NOT_FOUND, k, '0, '0, 1'b1});
                end
                else
                begin
                    cnt = tab_count[hit];
                    if (cnt < CNT_MAX)
                        cnt++;
                    sq = tab_seq[hit];
                    if (sq == 0)
                    begin
                        sq = seq_next;
                        if (seq_next < SEQ_TOP)
                            seq_next++;
                    end
                    // Walk forward past lower counts and later first accesses.
                    dst = hit;
                    while (dst > 0 && !(tab_count[dst-1] > cnt ||
                                        (tab_count[dst-1] == cnt && tab_seq[dst-1] < sq)))
                        dst--;
                    for (i = hit; i > dst; i--)
                    begin
                        tab_key[i]   = tab_key[i-1];
                        tab_count[i] = tab_count[i-1];
                        tab_seq[i]   = tab_seq[i-1];
                    end
                    tab_key[dst]   = k;
                    tab_count[dst] = cnt;
                    tab_seq[dst]   = sq;
                    reports_due.push_back('{ST_OK, k, CNT_OUT_W'(cnt), POS_W'(dst), 1'b1});
                end
            end
            ACT_DUMP:
            begin
                if (tab_used == 0)
                    reports_due.push_back('{ST_EMPTY, '0, '0, '0, 1'b1});
                for (i = 0; i < tab_used && i < MAX_RESULTS; i++)
                    reports_due.push_back('{ST_OK, tab_key[i], CNT_OUT_W'(tab_count[i]),
                                            POS_W'(i), (i + 1 == tab_used)});
            end
            default:
            begin
            end
        endcase
    endfunction

    // Offer one command and wait for the block to take it.
    task automatic offer_command(input logic [1:0] act, input logic [KEY_W-1:0] k,
                                 input bit typed, input report_t typed_rep);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        cmd_if.valid  <= 1'b1;
        cmd_if.action <= act;
        cmd_if.key    <= k;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        commands_sent++;
        apply_list_command(act, k);
        // A typed row stands in for the shadow table's own answer.
        if (typed)
        begin
            void'(reports_due.pop_back());
            reports_due.push_back(typed_rep);
        end
    endtask

    // Park the command side until every outstanding result has come back.
    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        @(posedge clk);
        while (reports_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic compare_field(input string name, input logic [KEY_W-1:0] want,
                                 input logic [KEY_W-1:0] got);
        if (want !== got)
        begin
            failures++;
            $error("%s: expected %0h, got %0h", name, want, got);
        end
    endtask

    // Command stimulus: reset, directed rows, random commands, front-entry lookups.
    initial
    begin
        logic [1:0]       act;
        logic [KEY_W-1:0] k;
        int               roll;
        rst_n         = 1'b0;
        cmd_if.valid  = 1'b0;
        cmd_if.action = ACT_APPEND;
        cmd_if.key    = '0;
        tab_used      = 0;
        seq_next      = 1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[r])
            offer_command(DIRECTED[r].act, DIRECTED[r].key, DIRECTED[r].typed,
                          DIRECTED[r].rep);

        // Mostly lookups of keys in the table, so entries climb and reorder.
        for (int n = 0; n < RANDOM_COMMANDS; n++)
        begin
            if (n == DRAIN_MARK)
                drain_results();
            if (n == RANDOM_COMMANDS - QUIET_TAIL)
                quiet = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 10)
                act = ACT_APPEND;
            else if (roll < 78)
                act = ACT_ACCESS;
            else if (roll < 93)
                act = ACT_DUMP;
            else
                act = ACT_RESERVED;
            roll = $urandom_range(0, 99);
            if (tab_used != 0 && roll < ((act == ACT_ACCESS) ? 85 : 25))
                k = tab_key[$urandom_range(0, tab_used - 1)];
            else
                k = $urandom();
            offer_command(act, k, 1'b0, '0);
        end

        // Repeated lookups of the front entry, back to back.
        k = tab_key[0];
        repeat (HAMMER_COMMANDS)
            offer_command(ACT_ACCESS, k, 1'b0, '0);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Result side: random stalls, plus one long hold that backs the block up.
    initial
    begin
        int stall_left;
        int hold_left;
        bit hold_done;
        stall_left   = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        res_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!hold_done && commands_sent >= HOLD_MARK)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_if.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                stall_left   = $urandom_range(1, 10) - 1;
                res_if.ready <= 1'b0;
            end
            else
            begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Check each result transaction against the oldest outstanding one.
    always @(posedge clk)
    begin
        report_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (reports_due.size() == 0)
            begin
                failures++;
                $error("result with nothing outstanding: entry_value %0h",
                       res_if.entry_value);
            end
            else
            begin
                want = reports_due.pop_front();
                compare_field("status", want.status, res_if.status);
                compare_field("entry_value", want.entry_value, res_if.entry_value);
                compare_field("access_count", want.access_count, res_if.access_count);
                compare_field("position", want.position, res_if.position);
                compare_field("last", want.last, res_if.last);
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[frequency_ordered_list.f]
+incdir+hw/rtl
hw/rtl/fol_pkg.sv
hw/rtl/fol_in_if.sv
hw/rtl/fol_out_if.sv
hw/rtl/fol_ram.sv
hw/rtl/fol_ctrl.sv
hw/rtl/fol_datapath.sv
hw/rtl/frequency_ordered_list.sv
hw/rtl/fol_checker.sv
tb/sv/tb_frequency_ordered_list.sv
